### design/cfse_pkg.sv
// Shared constants and types of the control frame stuffing encoder.
package cfse_pkg;

    localparam logic [7:0] FRAME_MARK   = 8'hFF;
    localparam logic [7:0] FRAME_START  = 8'h01;
    localparam logic [7:0] FRAME_ESCAPE = 8'h00;
    localparam logic [7:0] FRAME_END    = 8'h02;
    localparam logic [7:0] MODE_LOCKED  = 8'h80;
    localparam logic [7:0] MODE_HEAD    = 8'h40;

    localparam int PAYLOAD_LEN = 7;
    localparam int IDX_W       = $clog2(PAYLOAD_LEN);

    // One queued frame: the seven payload bytes and a flag per byte that is FF.
    typedef struct packed {
        logic [PAYLOAD_LEN-1:0][7:0] bytes;
        logic [PAYLOAD_LEN-1:0]      mark;
    } t_frame;

endpackage

### design/cfse_if.sv
// Handshake channels of the encoder: control record in, frame word out.
interface cfse_rec_if;
    logic              valid;
    logic              ready;
    logic              locked;
    logic              head_mode;
    logic [7:0]        power;
    logic signed [7:0] left_right;
    logic signed [7:0] fore_back;
    logic signed [7:0] spin;
    logic [7:0]        trim;

    modport source (output valid, locked, head_mode, power, left_right, fore_back, spin,
                    trim, input ready);
    modport sink (input valid, locked, head_mode, power, left_right, fore_back, spin,
                  trim, output ready);
endinterface

interface cfse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, frame_byte, last, input ready);
    modport sink (input valid, frame_byte, last, output ready);
endinterface

### design/control_frame_stuffing_encoder_unit.sv
// Top level of the control frame stuffing encoder: front end, frame queue, back end.
//
// Usage:
//   i_rec carries one control record per word (lock and head-mode flags, power,
//   three signed stick axes, trim). o_frm carries the framed bytes, one per word:
//   FF 01, the seven payload bytes (mode, power, LR, FB, SP, trim, 8-bit sum)
//   with any FF payload byte sent as FF 00, then FF 02 with last high.
//   A frame is 11 to 16 words long: the mode byte is never FF, and the sum
//   cannot be FF while all five other payload bytes are.
// An accepted record is written into the queue, then loaded into the back end's frame
//   register, from which its first byte is registered into the output register.
// Throughput: one output word per cycle while o_frm.ready is high, set by the single
//   output register; a record takes 7 + 4 + (number of FF payload bytes) words.
//   Frames follow each other without a gap: the next frame is popped from the
//   queue in the cycle that the closing 02 is loaded.
// Records are taken whenever the queue has room (QUEUE_DEPTH entries), even
//   while the back end is sending or the receiver holds off.
// Reset: empties the queue, drops any frame in flight and clears o_frm.valid.
// Stall: with o_frm.ready low the output word holds and the back end waits;
//   the front end keeps filling the queue until it is full, then drops i_rec.ready.
module control_frame_stuffing_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfse_rec_if.sink    i_rec,
    cfse_byte_if.source o_frm
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LW-1:0] LVL_FULL = LW'(QUEUE_DEPTH);

    // front end -> queue
    logic             w_push;
    logic             w_full;
    cfse_pkg::t_frame w_push_entry;

    // queue -> back end
    logic             w_pop;
    logic             w_avail;
    cfse_pkg::t_frame w_head_entry;
    logic [LW-1:0]    w_level;

    // Build payload, checksum and FF marks; push when the queue has room.
    cfse_front u_front (
        .i_rec   (i_rec),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Hold classified frames so intake and output stall independently.
    cfse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_entry),
        .o_avail (w_avail),
        .o_level (w_level)
    );

    // Advance through one frame, one word per cycle while o_frm.ready is high.
    cfse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_data  (w_head_entry),
        .o_pop   (w_pop),
        .o_frm   (o_frm)
    );

    // The queue never holds more than its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LVL_FULL)
        else $error("frame queue level beyond depth");

    // A push never lands on a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_level != LVL_FULL))
        else $error("frame queue overflow");

    // The back end pops only a queue that holds a frame.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_level != '0))
        else $error("frame queue underflow");

    // A record taken into an empty queue shows up as a level of one next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && w_level == '0) |=> (w_level == LW'(1)))
        else $error("pushed frame not counted");

endmodule

### design/cfse_front.sv
// Front end: accept a control record, build the payload and checksum, mark FF bytes.
module cfse_front (
    cfse_rec_if.sink         i_rec,
    input  logic             i_full,
    output logic             o_push,
    output cfse_pkg::t_frame o_entry
);

    logic [7:0] w_mode;
    logic [7:0] w_sum;

    assign w_mode = (i_rec.locked ? cfse_pkg::MODE_LOCKED : 8'h00) |
                    (i_rec.head_mode ? cfse_pkg::MODE_HEAD : 8'h00);

    // Checksum wraps at 256.
    assign w_sum = 8'(w_mode + i_rec.power + $unsigned(i_rec.left_right)
                      + $unsigned(i_rec.fore_back) + $unsigned(i_rec.spin) + i_rec.trim);

    always_comb begin
        o_entry.bytes[0] = w_mode;
        o_entry.bytes[1] = i_rec.power;
        o_entry.bytes[2] = $unsigned(i_rec.left_right);
        o_entry.bytes[3] = $unsigned(i_rec.fore_back);
        o_entry.bytes[4] = $unsigned(i_rec.spin);
        o_entry.bytes[5] = i_rec.trim;
        o_entry.bytes[6] = w_sum;
        for (int k = 0; k < cfse_pkg::PAYLOAD_LEN; k++) begin
            o_entry.mark[k] = (o_entry.bytes[k] == cfse_pkg::FRAME_MARK);
        end
    end

    assign i_rec.ready = !i_full;
    assign o_push      = i_rec.valid && !i_full;

endmodule

### design/cfse_fifo.sv
// Short queue of classified frames between front and back end.
module cfse_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  cfse_pkg::t_frame           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output cfse_pkg::t_frame           o_data,
    output logic                       o_avail,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [LW-1:0] LVL_FULL = LW'(DEPTH);

    cfse_pkg::t_frame r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [LW-1:0] r_level,  n_level;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_level = LW'(r_level + 1'b1);
        end else if (!i_push && i_pop) begin
            n_level = LW'(r_level - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_level == LVL_FULL);
    assign o_avail = (r_level != '0);
    assign o_level = r_level;

endmodule

### design/cfse_back.sv
// Back end: walk one frame and send it a word per cycle, while the receiver is ready, through an output register.
module cfse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  cfse_pkg::t_frame i_data,
    output logic             o_pop,
    cfse_byte_if.source      o_frm
);

    localparam logic [2:0] ST_HEAD_MARK  = 3'd0;
    localparam logic [2:0] ST_HEAD_START = 3'd1;
    localparam logic [2:0] ST_BODY       = 3'd2;
    localparam logic [2:0] ST_TAIL_MARK  = 3'd3;
    localparam logic [2:0] ST_TAIL_END   = 3'd4;

    localparam logic [cfse_pkg::IDX_W-1:0] IDX_LAST = cfse_pkg::IDX_W'(cfse_pkg::PAYLOAD_LEN - 1);

    logic [2:0]                 r_state, n_state;
    logic                       r_busy,  n_busy;
    logic [cfse_pkg::IDX_W-1:0] r_idx,   n_idx;
    logic                       r_esc,   n_esc;
    cfse_pkg::t_frame           r_frame, n_frame;
    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_out_byte,  n_out_byte;
    logic                       r_out_last,  n_out_last;

    logic w_emit;
    logic w_done;
    logic w_load;

    assign w_emit = r_busy && (!r_out_valid || o_frm.ready);
    assign w_done = w_emit && (r_state == ST_TAIL_END);
    assign w_load = i_avail && (!r_busy || w_done);

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_esc       = r_esc;
        n_frame     = r_frame;
        n_out_valid = r_out_valid && !o_frm.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b0;
            unique case (r_state)
                ST_HEAD_MARK: begin
                    n_out_byte = cfse_pkg::FRAME_MARK;
                    n_state    = ST_HEAD_START;
                end
                ST_HEAD_START: begin
                    n_out_byte = cfse_pkg::FRAME_START;
                    n_state    = ST_BODY;
                    n_idx      = '0;
                    n_esc      = 1'b0;
                end
                ST_BODY: begin
                    if (r_esc) begin
                        n_out_byte = cfse_pkg::FRAME_ESCAPE;
                        n_esc      = 1'b0;
                    end else if (r_frame.mark[r_idx]) begin
                        n_out_byte = cfse_pkg::FRAME_MARK;
                        n_esc      = 1'b1;
                    end else begin
                        n_out_byte = r_frame.bytes[r_idx];
                    end
                    // advance once the byte (and its escape, if any) is out
                    if (r_esc || !r_frame.mark[r_idx]) begin
                        if (r_idx == IDX_LAST) begin
                            n_state = ST_TAIL_MARK;
                        end else begin
                            n_idx = cfse_pkg::IDX_W'(r_idx + 1'b1);
                        end
                    end
                end
                ST_TAIL_MARK: begin
                    n_out_byte = cfse_pkg::FRAME_MARK;
                    n_state    = ST_TAIL_END;
                end
                ST_TAIL_END: begin
                    n_out_byte = cfse_pkg::FRAME_END;
                    n_out_last = 1'b1;
                    n_busy     = 1'b0;
                end
                default: begin
                    n_state = ST_HEAD_MARK;
                    n_busy  = 1'b0;
                end
            endcase
        end

        if (w_load) begin
            n_busy  = 1'b1;
            n_frame = i_data;
            n_state = ST_HEAD_MARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HEAD_MARK;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_esc       <= n_esc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame    <= n_frame;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_pop            = w_load;
    assign o_frm.valid      = r_out_valid;
    assign o_frm.frame_byte = r_out_byte;
    assign o_frm.last       = r_out_last;

endmodule

### tb/testbench.sv
// Self-checking testbench of the control frame stuffing encoder: directed table, then random records.
module testbench;

    // One control record plus, for directed rows, a checksum typed in by hand.
    typedef struct packed {
        logic              locked;
        logic              head_mode;
        logic [7:0]        power;
        logic signed [7:0] left_right;
        logic signed [7:0] fore_back;
        logic signed [7:0] spin;
        logic [7:0]        trim;
        logic              sum_given;
        logic [7:0]        sum_typed;
    } t_ctrl_row;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_frame_word;

    localparam int DIR_ROWS  = 20;
    localparam int RAND_RECS = 452;

    logic i_clk;
    logic i_rst_n;

    cfse_rec_if  rec ();
    cfse_byte_if frm ();

    control_frame_stuffing_encoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec),
        .o_frm   (frm)
    );

    t_frame_word frame_words_q[$];
    int          mismatches = 0;
    int          recs_taken = 0;
    bit          word_taken = 0;
    bit          rx_hold    = 0;
    bit          tx_burst   = 0;

    // Directed rows: locked, head_mode, power, LR, FB, SP, trim, checksum typed?, checksum.
    // Where the checksum is typed, the expected frame is built with it instead of the sum.
    t_ctrl_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, // all zero
        '{1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h80}, // lock bit only
        '{1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h40}, // head bit only
        '{1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hC0}, // both flags
        '{1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, // power FF, sum FF
        '{1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, // LR -1
        '{1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF}, // FB -1
        '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 8'hFF}, // SP -1
        '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 8'hFF}, // trim FF
        '{1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hBB}, // longest frame
        '{1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFB}, // five stuffed bytes
        '{1'b1, 1'b0, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, // only checksum stuffed
        '{1'b0, 1'b0, 8'h00, 8'h80, 8'h7F, 8'h00, 8'h00, 1'b1, 8'hFF}, // axis -128 and 127
        '{1'b0, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 1'b1, 8'h03}, // start/end codes inside
        '{1'b0, 1'b1, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 1'b1, 8'hC0}, // all axes at -128
        '{1'b0, 1'b0, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h00, 1'b1, 8'h7D}, // all axes at 127
        '{1'b1, 1'b0, 8'h12, 8'hFB, 8'h21, 8'hB3, 8'hA5, 1'b0, 8'h00},
        '{1'b0, 1'b1, 8'hFE, 8'h01, 8'hFD, 8'h02, 8'hFC, 1'b0, 8'h00},
        '{1'b1, 1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 8'h00},
        '{1'b0, 1'b0, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 8'h00}
    };

    // 20 time unit period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] mode_byte(input t_ctrl_row r);
        return (r.locked ? cfse_pkg::MODE_LOCKED : 8'h00) |
               (r.head_mode ? cfse_pkg::MODE_HEAD : 8'h00);
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic is_last);
        t_frame_word w;
        w.frame_byte = b;
        w.last       = is_last;
        frame_words_q.push_back(w);
    endfunction

    // Build the stuffed frame of one record and queue its words in transmit order.
    function automatic void predict_frame(input t_ctrl_row r);
        logic [7:0] payload [cfse_pkg::PAYLOAD_LEN];
        logic [7:0] sum;
        payload[0] = mode_byte(r);
        payload[1] = r.power;
        payload[2] = r.left_right;
        payload[3] = r.fore_back;
        payload[4] = r.spin;
        payload[5] = r.trim;
        sum = 8'h00;
        for (int i = 0; i < cfse_pkg::PAYLOAD_LEN - 1; i++)
            sum = sum + payload[i];
        payload[6] = r.sum_given ? r.sum_typed : sum;
        push_word(cfse_pkg::FRAME_MARK, 1'b0);
        push_word(cfse_pkg::FRAME_START, 1'b0);
        for (int i = 0; i < cfse_pkg::PAYLOAD_LEN; i++) begin
            if (payload[i] == cfse_pkg::FRAME_MARK) begin
                push_word(cfse_pkg::FRAME_MARK, 1'b0);
                push_word(cfse_pkg::FRAME_ESCAPE, 1'b0);
            end else begin
                push_word(payload[i], 1'b0);
            end
        end
        push_word(cfse_pkg::FRAME_MARK, 1'b0);
        push_word(cfse_pkg::FRAME_END, 1'b1);
    endfunction

    // Favor the bytes that matter to stuffing and sign handling.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_ctrl_row rand_row();
        t_ctrl_row  r;
        logic [7:0] partial;
        r.locked     = 1'($urandom_range(0, 1));
        r.head_mode  = 1'($urandom_range(0, 1));
        r.power      = pick_byte();
        r.left_right = pick_byte();
        r.fore_back  = pick_byte();
        r.spin       = pick_byte();
        r.trim       = pick_byte();
        r.sum_given  = 1'b0;
        r.sum_typed  = 8'h00;
        // Now and then steer trim so that the checksum itself needs stuffing.
        if ($urandom_range(0, 7) == 0) begin
            partial = mode_byte(r) + r.power + r.left_right + r.fore_back + r.spin;
            r.trim  = cfse_pkg::FRAME_MARK - partial;
        end
        return r;
    endfunction

    // Offer one record after gap idle cycles; queue its frame once the word is taken.
    task automatic send_rec(input t_ctrl_row r, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            rec.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rec.locked     <= r.locked;
        rec.head_mode  <= r.head_mode;
        rec.power      <= r.power;
        rec.left_right <= r.left_right;
        rec.fore_back  <= r.fore_back;
        rec.spin       <= r.spin;
        rec.trim       <= r.trim;
        rec.valid      <= 1'b1;
        do @(posedge i_clk); while (!rec.ready);
        predict_frame(r);
        recs_taken++;
    endtask

    function automatic int draw_gap();
        return (rx_hold || tx_burst) ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic drain_frames();
        while (frame_words_q.size() != 0) @(posedge i_clk);
    endtask

    // Compare every word taken at a rising edge with the oldest expected word.
    always @(posedge i_clk) begin
        t_frame_word want;
        word_taken = i_rst_n && frm.valid && frm.ready;
        if (word_taken) begin
            if (frame_words_q.size() == 0) begin
                $error("unexpected word: frame_byte %h last %b", frm.frame_byte, frm.last);
                mismatches++;
            end else begin
                want = frame_words_q.pop_front();
                if (frm.frame_byte !== want.frame_byte) begin
                    $error("frame_byte: expected %h, got %h", want.frame_byte, frm.frame_byte);
                    mismatches++;
                end
                if (frm.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, frm.last);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: hold ready low for a random stall before each word, with stall-free stretches,
    // and hold ready low outright while a long hold-off is in force.
    initial begin
        int  stall_left;
        int  words_seen;
        bit  rx_burst;
        stall_left = 0;
        words_seen = 0;
        rx_burst   = 1'b0;
        frm.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (word_taken) begin
                words_seen++;
                if (words_seen % 50 == 0)
                    rx_burst = ($urandom_range(0, 2) == 0);
                stall_left = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (!i_rst_n || rx_hold) begin
                frm.ready <= 1'b0;
            end else if (stall_left > 0) begin
                frm.ready <= 1'b0;
                stall_left--;
            end else begin
                frm.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off once traffic is going: the sender keeps offering
    // records back to back, so the queue fills and input ready must drop.
    initial begin
        wait (recs_taken >= 60);
        rx_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Main stimulus: directed table, a full drain, then random records with a drain halfway.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rec.valid      = 1'b0;
        rec.locked     = 1'b0;
        rec.head_mode  = 1'b0;
        rec.power      = 8'h00;
        rec.left_right = 8'h00;
        rec.fore_back  = 8'h00;
        rec.spin       = 8'h00;
        rec.trim       = 8'h00;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_rec(dir_rows[i], draw_gap());

        // Pause the sender until every queued frame has gone out.
        @(negedge i_clk);
        rec.valid <= 1'b0;
        drain_frames();

        for (int i = 0; i < RAND_RECS; i++) begin
            if (i % 30 == 0)
                tx_burst = ($urandom_range(0, 2) == 0);
            if (i == RAND_RECS / 2) begin
                @(negedge i_clk);
                rec.valid <= 1'b0;
                drain_frames();
            end
            send_rec(rand_row(), draw_gap());
        end
        @(negedge i_clk);
        rec.valid <= 1'b0;

        // Let the last frames out, then watch a while for stray words.
        drain_frames();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("[control_frame_stuffing_encoder_unit] OK");
        else
            $display("[control_frame_stuffing_encoder_unit] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #15000000;
        $display("[control_frame_stuffing_encoder_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
design/cfse_pkg.sv
design/cfse_if.sv
design/cfse_front.sv
design/cfse_fifo.sv
design/cfse_back.sv
design/control_frame_stuffing_encoder_unit.sv
tb/testbench.sv
